// ===== rtl/core/longest_subarray_sum_divisible_assert.svh =====
// Assertion macros for the longest divisible-sum subarray block.
// Included by the top level; no other dependencies.
`ifndef LONGEST_SUBARRAY_SUM_DIVISIBLE_ASSERT_SVH
`define LONGEST_SUBARRAY_SUM_DIVISIBLE_ASSERT_SVH
`ifndef ASSERT_OFF
`define LSSD_ASSERT(lbl, prop, clk, rst_n) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lssd assertion failed");
`define LSSD_ASSERT_IMP(lbl, ante, cons, clk, rst_n) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lssd assertion failed");
`else
`define LSSD_ASSERT(lbl, prop, clk, rst_n)
`define LSSD_ASSERT_IMP(lbl, ante, cons, clk, rst_n)
`endif
`endif

// ===== rtl/core/lssd_pkg.sv =====
// Shared constants, types and helpers for the longest divisible-sum subarray block.
// No dependencies.
package lssd_pkg;

  localparam int unsigned MaxModulus = 256;
  localparam int unsigned MaxItems   = 65536;
  localparam int unsigned ValW       = 32;
  localparam int unsigned RemW       = $clog2(MaxModulus);
  localparam int unsigned ModW       = RemW + 1;
  localparam int unsigned FirstW     = $clog2(MaxItems);
  localparam int unsigned IdxW       = FirstW + 1;
  localparam int unsigned DigitBits  = 4;
  localparam int unsigned DivSteps   = ValW / DigitBits;
  localparam int unsigned CntW       = $clog2(DivSteps);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RED,
    ST_UPD
  } state_e;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic              clr;
    logic [RemW-1:0]   addr;
    logic [FirstW-1:0] wr_data;
  } tbl_req_t;

  // modulus 0 acts as 1, anything above the table size saturates
  function automatic logic [ModW-1:0] eff_k(input logic [ModW-1:0] m);
    logic [ModW-1:0] k;
    if (m == '0) begin
      k = ModW'(1);
    end else if (m > ModW'(MaxModulus)) begin
      k = ModW'(MaxModulus);
    end else begin
      k = m;
    end
    return k;
  endfunction

endpackage

// ===== rtl/core/lssd_if.sv =====
// Valid/ready channel interfaces: input request, result and modulus write.
// Depends on lssd_pkg.
interface lssd_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [lssd_pkg::ValW-1:0] value;
  logic                            last_item;
  modport source (output valid, value, last_item, input ready);
  modport sink   (input valid, value, last_item, output ready);
endinterface

interface lssd_out_if;
  logic                      valid;
  logic                      ready;
  logic [lssd_pkg::IdxW-1:0] longest_length;
  logic                      is_last;
  logic                      overflow;
  modport source (output valid, longest_length, is_last, overflow, input ready);
  modport sink   (input valid, longest_length, is_last, overflow, output ready);
endinterface

interface lssd_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [lssd_pkg::ModW-1:0] modulus;
  modport source (output valid, modulus, input ready);
  modport sink   (input valid, modulus, output ready);
endinterface

// ===== rtl/core/lssd_divmod.sv =====
// Iterative remainder unit: 32-bit magnitude mod k, four bits per cycle.
// Depends on lssd_pkg.
module lssd_divmod (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [lssd_pkg::ValW-1:0] mag_i,
  input  logic [lssd_pkg::ModW-1:0] k_i,
  output logic                      done_o,
  output logic [lssd_pkg::RemW-1:0] rem_o
);

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [lssd_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [lssd_pkg::ValW-1:0] mag_q, mag_d;
  logic [lssd_pkg::RemW-1:0] r_q, r_d;
  logic [lssd_pkg::RemW-1:0] r_step;
  logic [lssd_pkg::ModW-1:0] t;

  always_comb begin
    r_step = r_q;
    for (int j = 0; j < lssd_pkg::DigitBits; j++) begin
      t = {r_step, mag_q[lssd_pkg::ValW-1-j]};
      if (t >= k_i) begin
        t = t - k_i;
      end
      r_step = t[lssd_pkg::RemW-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    mag_d  = mag_q;
    r_d    = r_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      mag_d  = mag_i;
      r_d    = '0;
    end else if (busy_q) begin
      r_d   = r_step;
      mag_d = mag_q << lssd_pkg::DigitBits;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == lssd_pkg::CntW'(lssd_pkg::DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    r_q   <= r_d;
  end

  assign done_o = done_q;
  assign rem_o  = r_q;

endmodule

// ===== rtl/core/lssd_table.sv =====
// First-index table: synchronous memory indexed by remainder, plus per-entry valid bits.
// Depends on lssd_pkg.
module lssd_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lssd_pkg::tbl_req_t          req_i,
  output logic [lssd_pkg::FirstW-1:0] rd_data_o,
  output logic                        rd_valid_o
);

  logic [lssd_pkg::FirstW-1:0]     mem_q [lssd_pkg::MaxModulus];
  logic [lssd_pkg::MaxModulus-1:0] valid_q;
  logic [lssd_pkg::FirstW-1:0]     rd_data_q;
  logic                            rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q  <= mem_q[req_i.addr];
      rd_valid_q <= valid_q[req_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.clr) begin
      valid_q <= '0;
    end else if (req_i.wr_en) begin
      valid_q[req_i.addr] <= 1'b1;
    end
  end

  assign rd_data_o  = rd_data_q;
  assign rd_valid_o = rd_valid_q;

endmodule

// ===== rtl/core/longest_subarray_sum_divisible.sv =====
// Longest subarray with sum divisible by k: top level, FSM and running state.
// Each accepted request passes ST_DIV (remainder unit), ST_RED (table read) and ST_UPD,
// where the result is registered; a request past the item limit goes straight to ST_UPD.
// A new request is taken only back in ST_IDLE, so each waits for the last to finish.
// Reset: modulus 3, array state and all table valid bits cleared at once; table data undefined.
// Depends on lssd_pkg, lssd_if, lssd_divmod, lssd_table and the assertion header.
`include "longest_subarray_sum_divisible_assert.svh"

module longest_subarray_sum_divisible (
  input  logic        clk_i,
  input  logic        rst_ni,
  lssd_in_if.sink     in_i,
  lssd_out_if.source  out_o,
  lssd_cfg_if.sink    cfg_i
);

  lssd_pkg::state_e state_q, state_d;

  logic [lssd_pkg::ModW-1:0]   modulus_q, modulus_d;
  logic [lssd_pkg::RemW-1:0]   rem_q, rem_d;
  logic [lssd_pkg::IdxW-1:0]   idx_q, idx_d;
  logic [lssd_pkg::IdxW-1:0]   best_q, best_d;
  logic                        ovf_q, ovf_d;
  logic                        out_valid_q, out_valid_d;

  logic                        neg_q, neg_d;
  logic                        last_q, last_d;
  logic                        skip_q, skip_d;
  logic [lssd_pkg::RemW-1:0]   new_rem_q, new_rem_d;
  logic [lssd_pkg::IdxW-1:0]   out_len_q, out_len_d;
  logic                        out_last_q, out_last_d;
  logic                        out_ovf_q, out_ovf_d;

  logic [lssd_pkg::ModW-1:0]   k;
  logic [lssd_pkg::ValW-1:0]   mag;
  logic                        div_start;
  logic                        div_done;
  logic [lssd_pkg::RemW-1:0]   div_rem;
  logic [lssd_pkg::ModW-1:0]   vm9;
  logic [lssd_pkg::ModW-1:0]   sum9;
  logic [lssd_pkg::IdxW-1:0]   len;
  logic [lssd_pkg::FirstW-1:0] first;
  logic                        first_valid;
  logic                        in_fire;
  logic                        cfg_fire;
  logic                        upd_fire;
  logic                        clear_arr;
  lssd_pkg::tbl_req_t          tbl_req;

  assign k        = lssd_pkg::eff_k(modulus_q);
  assign mag      = in_i.value[lssd_pkg::ValW-1] ? (~in_i.value + 1'b1) : in_i.value;
  assign cfg_i.ready = (state_q == lssd_pkg::ST_IDLE);
  assign in_i.ready  = (state_q == lssd_pkg::ST_IDLE) && !cfg_i.valid;
  assign in_fire  = in_i.valid && in_i.ready;
  assign cfg_fire = cfg_i.valid && cfg_i.ready;
  assign upd_fire = !out_valid_q || out_o.ready;
  assign len      = idx_q - {1'b0, first};

  lssd_divmod u_divmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .mag_i   (mag),
    .k_i     (k),
    .done_o  (div_done),
    .rem_o   (div_rem)
  );

  lssd_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (tbl_req),
    .rd_data_o  (first),
    .rd_valid_o (first_valid)
  );

  // element remainder folded into the running prefix remainder
  always_comb begin
    vm9 = (neg_q && (div_rem != '0)) ? (k - {1'b0, div_rem}) : {1'b0, div_rem};
    sum9 = {1'b0, rem_q} + vm9;
    if (sum9 >= k) begin
      sum9 = sum9 - k;
    end
  end

  always_comb begin
    state_d     = state_q;
    modulus_d   = modulus_q;
    rem_d       = rem_q;
    idx_d       = idx_q;
    best_d      = best_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_o.ready;
    neg_d       = neg_q;
    last_d      = last_q;
    skip_d      = skip_q;
    new_rem_d   = new_rem_q;
    out_len_d   = out_len_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    div_start   = 1'b0;
    clear_arr   = 1'b0;
    tbl_req     = '0;
    tbl_req.addr = new_rem_q;
    tbl_req.wr_data = idx_q[lssd_pkg::FirstW-1:0];

    unique case (state_q)
      lssd_pkg::ST_IDLE: begin
        if (cfg_fire) begin
          modulus_d = cfg_i.modulus;
          clear_arr = 1'b1;
        end else if (in_fire) begin
          neg_d  = in_i.value[lssd_pkg::ValW-1];
          last_d = in_i.last_item;
          skip_d = idx_q[lssd_pkg::IdxW-1];
          if (idx_q[lssd_pkg::IdxW-1]) begin
            state_d = lssd_pkg::ST_UPD;
          end else begin
            div_start = 1'b1;
            state_d   = lssd_pkg::ST_DIV;
          end
        end
      end
      lssd_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = lssd_pkg::ST_RED;
        end
      end
      lssd_pkg::ST_RED: begin
        new_rem_d     = sum9[lssd_pkg::RemW-1:0];
        tbl_req.rd_en = 1'b1;
        tbl_req.addr  = sum9[lssd_pkg::RemW-1:0];
        state_d       = lssd_pkg::ST_UPD;
      end
      lssd_pkg::ST_UPD: begin
        if (upd_fire) begin
          if (skip_q) begin
            ovf_d = 1'b1;
          end else begin
            rem_d = new_rem_q;
            idx_d = idx_q + 1'b1;
            if (new_rem_q == '0) begin
              best_d = idx_q + 1'b1;
            end else if (!first_valid) begin
              tbl_req.wr_en = 1'b1;
            end else if (len > best_q) begin
              best_d = len;
            end
          end
          out_valid_d = 1'b1;
          out_len_d   = best_d;
          out_last_d  = last_q;
          out_ovf_d   = ovf_d;
          clear_arr   = last_q;
          state_d     = lssd_pkg::ST_IDLE;
        end
      end
    endcase

    if (clear_arr) begin
      rem_d       = '0;
      idx_d       = '0;
      best_d      = '0;
      ovf_d       = 1'b0;
      tbl_req.clr = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lssd_pkg::ST_IDLE;
      modulus_q   <= lssd_pkg::ModW'(3);
      rem_q       <= '0;
      idx_q       <= '0;
      best_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      modulus_q   <= modulus_d;
      rem_q       <= rem_d;
      idx_q       <= idx_d;
      best_q      <= best_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q      <= neg_d;
    last_q     <= last_d;
    skip_q     <= skip_d;
    new_rem_q  <= new_rem_d;
    out_len_q  <= out_len_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.longest_length = out_len_q;
  assign out_o.is_last        = out_last_q;
  assign out_o.overflow       = out_ovf_q;

  `LSSD_ASSERT(a_busy_after_req, (in_i.valid && in_i.ready) |=> !in_i.ready, clk_i, rst_ni)
  `LSSD_ASSERT_IMP(a_rem_below_k, 1'b1, {1'b0, rem_q} < k, clk_i, rst_ni)
  `LSSD_ASSERT_IMP(a_best_le_idx, 1'b1, best_q <= idx_q, clk_i, rst_ni)

endmodule

// ===== test/tb_longest_subarray_sum_divisible.sv =====
// Self-checking bench for longest_subarray_sum_divisible: drives signed elements and modulus
// writes, predicts each longest-length result and compares it field by field.
// Depends on lssd_pkg, the lssd channel interfaces and the top level.
module tb_longest_subarray_sum_divisible;
  import lssd_pkg::*;

  typedef struct packed {
    logic [IdxW-1:0] longest_length;
    logic            is_last;
    logic            overflow;
  } span_result_t;

  localparam int unsigned ResultLatency = 12;
  localparam int unsigned RandomItems   = 1050;

  logic clk_i;
  logic rst_ni;

  lssd_in_if  in_if ();
  lssd_out_if out_if ();
  lssd_cfg_if cfg_if ();

  longest_subarray_sum_divisible i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // prefix-remainder tracker state
  logic [ModW-1:0]   modulus_reg;
  logic [RemW-1:0]   prefix_rem;
  logic [IdxW-1:0]   array_len;
  logic [IdxW-1:0]   best_len;
  logic [FirstW-1:0] first_seen [MaxModulus];
  bit                rem_seen   [MaxModulus];
  bit                limit_hit;

  span_result_t pending_spans [$];
  int unsigned  error_count;
  int unsigned  items_sent;
  int unsigned  rx_stall;
  bit           rx_idle_en;
  bit           tx_idle_en;
  bit           req_held;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #100000000;
    $display("longest_subarray_sum_divisible: mismatch");
    $finish;
  end

  function automatic void clear_array_state();
    prefix_rem = '0;
    array_len  = '0;
    best_len   = '0;
    limit_hit  = 1'b0;
    foreach (rem_seen[j]) rem_seen[j] = 1'b0;
  endfunction

  function automatic int unsigned divisor();
    if (modulus_reg == '0) return 1;
    if (modulus_reg > ModW'(MaxModulus)) return MaxModulus;
    return int'(modulus_reg);
  endfunction

  function automatic span_result_t predict_span(logic signed [ValW-1:0] value, logic last);
    longint          k;
    longint          v;
    longint          vm;
    int unsigned     r;
    logic [IdxW-1:0] span;
    span_result_t    res;
    k = longint'(divisor());
    v = longint'(value);
    if (array_len >= IdxW'(MaxItems)) begin
      limit_hit = 1'b1;
      array_len = IdxW'(MaxItems);
    end else begin
      vm = ((v % k) + k) % k;
      r  = int'((longint'(prefix_rem) + vm) % k);
      prefix_rem = r[RemW-1:0];
      if (r == 0) begin
        best_len = array_len + 1'b1;
      end else if (!rem_seen[r]) begin
        rem_seen[r]   = 1'b1;
        first_seen[r] = array_len[FirstW-1:0];
      end else begin
        span = array_len - IdxW'(first_seen[r]);
        if (span > best_len) best_len = span;
      end
      array_len = array_len + 1'b1;
    end
    res.longest_length = best_len;
    res.is_last        = last;
    res.overflow       = limit_hit;
    if (last) clear_array_state();
    return res;
  endfunction

  // mostly back-to-back, sometimes a short gap, rarely a long gap
  function automatic int unsigned idle_len(bit enabled);
    int unsigned r;
    if (!enabled) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic signed [ValW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(9);
    case (r)
      3, 4:    return ValW'($signed($urandom_range(40)) - 20);
      5:       return ValW'(int'(divisor()) * (int'($urandom_range(4000)) - 2000));
      6: begin
        case ($urandom_range(3))
          0:       return 32'sh8000_0000;
          1:       return 32'sh7fff_ffff;
          2:       return -32'sd1;
          default: return 32'sd0;
        endcase
      end
      default: return ValW'($urandom);
    endcase
  endfunction

  // result checker and random backpressure
  always @(posedge clk_i) begin
    span_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_spans.size() == 0) begin
        $error("unexpected result: longest_length %0d", out_if.longest_length);
        error_count++;
      end else begin
        want = pending_spans.pop_front();
        if (out_if.longest_length !== want.longest_length) begin
          $error("longest_length: expected %0d, got %0d",
                 want.longest_length, out_if.longest_length);
          error_count++;
        end
        if (out_if.is_last !== want.is_last) begin
          $error("is_last: expected %0b, got %0b", want.is_last, out_if.is_last);
          error_count++;
        end
        if (out_if.overflow !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, out_if.overflow);
          error_count++;
        end
      end
    end
    if (rx_stall > 0) begin
      out_if.ready <= 1'b0;
      rx_stall     <= rx_stall - 1;
    end else begin
      out_if.ready <= 1'b1;
      rx_stall     <= idle_len(rx_idle_en);
    end
  end

  task automatic send_item(input logic signed [ValW-1:0] value, input logic last);
    int unsigned gap;
    in_if.valid     <= 1'b1;
    in_if.value     <= value;
    in_if.last_item <= last;
    req_held = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    pending_spans.push_back(predict_span(value, last));
    items_sent++;
    gap = idle_len(tx_idle_en);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      req_held = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    if (req_held) begin
      in_if.valid <= 1'b0;
      req_held = 1'b0;
    end
    while (pending_spans.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_modulus(input logic [ModW-1:0] m);
    wait_drained();
    cfg_if.valid   <= 1'b1;
    cfg_if.modulus <= m;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    modulus_reg = m;
    clear_array_state();
  endtask

  task automatic test_reset_modulus();
    send_item(32'sd1, 1'b0);
    send_item(32'sd2, 1'b0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(32'sh7fff_ffff, 1'b0);
    send_item(-32'sd1, 1'b0);
    send_item(32'sd0, 1'b0);
    send_item(32'sd5, 1'b1);
  endtask

  // 0 acts as 1, anything past the table size saturates
  task automatic test_modulus_limits();
    write_modulus(ModW'(0));
    send_item(32'sd7, 1'b0);
    send_item(-32'sd7, 1'b1);
    write_modulus(ModW'(1));
    send_item(32'sh8000_0000, 1'b0);
    send_item(32'sh7fff_ffff, 1'b1);
    write_modulus(ModW'(MaxModulus));
    send_item(32'sd256, 1'b0);
    send_item(-32'sd256, 1'b0);
    send_item(32'sh7fff_ffff, 1'b0);
    send_item(32'sd1, 1'b1);
    write_modulus({ModW{1'b1}});
    send_item(32'sd255, 1'b0);
    send_item(32'sd1, 1'b1);
  endtask

  // a write with an array open must start a fresh array
  task automatic test_write_mid_array();
    write_modulus(ModW'(5));
    send_item(32'sd4, 1'b0);
    send_item(32'sd3, 1'b0);
    send_item(32'sd2, 1'b0);
    write_modulus(ModW'(5));
    send_item(32'sd10, 1'b0);
    send_item(32'sd1, 1'b1);
  endtask

  task automatic test_random_arrays();
    int unsigned      start_count;
    int unsigned      arrays;
    int unsigned      len;
    bit               open_end;
    logic [ModW-1:0]  m;
    start_count = items_sent;
    while (items_sent - start_count < RandomItems) begin
      case ($urandom_range(9))
        0:       m = ModW'(0);
        1:       m = ModW'(1);
        2:       m = ModW'(MaxModulus);
        3:       m = ModW'($urandom_range(511, MaxModulus + 1));
        4:       m = {ModW{1'b1}};
        5:       m = ModW'($urandom_range(511, 1));
        default: m = ModW'($urandom_range(16, 2));
      endcase
      write_modulus(m);
      tx_idle_en = ($urandom_range(3) != 0);
      rx_idle_en = ($urandom_range(3) != 0);
      arrays = $urandom_range(4, 1);
      for (int unsigned a = 0; a < arrays; a++) begin
        len      = ($urandom_range(7) == 0) ? $urandom_range(300, 25) : $urandom_range(24, 1);
        open_end = (a == arrays - 1) && ($urandom_range(5) == 0);
        for (int unsigned n = 0; n < len; n++) begin
          if (n == len / 2 && $urandom_range(9) == 0) wait_drained();
          send_item(pick_value(), (n == len - 1) && !open_end);
        end
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.value     = '0;
    in_if.last_item = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.modulus  = ModW'(3);
    out_if.ready    = 1'b0;
    rx_stall        = 0;
    rx_idle_en      = 1'b1;
    tx_idle_en      = 1'b1;
    req_held        = 1'b0;
    error_count     = 0;
    items_sent      = 0;
    modulus_reg     = ModW'(3);
    clear_array_state();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_modulus();
    test_modulus_limits();
    test_write_mid_array();
    test_random_arrays();

    wait_drained();
    repeat (2 * ResultLatency) @(posedge clk_i);
    if (error_count == 0) begin
      $display("longest_subarray_sum_divisible: match");
    end else begin
      $display("longest_subarray_sum_divisible: mismatch");
    end
    $finish;
  end

endmodule
